@@ hw/rtl/dedup_set_sorted_readout_defines.svh @@
// Assertion macros shared by the dedup set RTL.
// Needs a clock i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef DEDUP_SET_SORTED_READOUT_DEFINES_SVH
`define DEDUP_SET_SORTED_READOUT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dss_pkg.sv @@
// Types and constants for the deduplicating index set.
// No dependencies; used by every module of the block.
package dss_pkg;

    localparam int IDX_W = 31;
    localparam int OCC_W = 6;
    localparam int ST_W  = 3;

    typedef enum logic [ST_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_ELEMENT = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_READOUT = 1'b1
    } t_op;

    // result of the shared comparator
    typedef struct packed {
        logic eq;      // data == key
        logic gt_key;  // data >  key
        logic lt_min;  // data <  running minimum
    } t_cmp_res;

endpackage

@@ hw/rtl/dss_store.sv @@
// Entry store: one write port, one read port with registered read data.
// Depends on dss_pkg for the entry width.
module dss_store
    import dss_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [IDX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [IDX_W-1:0] o_rdata
);

    logic [IDX_W-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dss_cmp.sv @@
// Shared comparator: equality and ordering of one stored entry.
// Depends on dss_pkg for t_cmp_res and the entry width.
module dss_cmp
    import dss_pkg::*;
(
    input  logic [IDX_W-1:0] i_data,
    input  logic [IDX_W-1:0] i_key,
    input  logic [IDX_W-1:0] i_min,
    output t_cmp_res         o_res
);

    always_comb begin
        o_res.eq     = (i_data == i_key);
        o_res.gt_key = (i_data >  i_key);
        o_res.lt_min = (i_data <  i_min);
    end

endmodule

@@ hw/rtl/dedup_set_sorted_readout.sv @@
// Top level of the deduplicating index set with sorted readout.
// Depends on dss_pkg, dss_store, dss_cmp and the assertion macro header.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -----------------------------------------------
//  command   start / busy           i_operation, i_index_value
//  result    o_strobe (one cycle)   o_status, o_element, o_occupancy, o_last
//
// An insert scans all n stored entries through the one store read port while busy,
// with its result in the cycle after. A readout does one scan per element, picking
// the smallest entry above the one last sent, and is busy until the last element.
// A readout of an empty set answers in the next cycle without going busy.
// Synchronous reset empties the set; store contents are only read below the count.
// Results cannot be stalled; each strobe lasts exactly one cycle.
`include "dedup_set_sorted_readout_defines.svh"

module dedup_set_sorted_readout
    import dss_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_operation,
    input  logic [IDX_W-1:0] i_index_value,
    output logic             o_strobe,
    output logic [ST_W-1:0]  o_status,
    output logic [IDX_W-1:0] o_element,
    output logic [OCC_W-1:0] o_occupancy,
    output logic             o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_RD
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_emit_cnt, n_emit_cnt;
    logic               r_pend, n_pend;
    logic               r_found, n_found;
    logic               r_have_thr, n_have_thr;
    logic               r_have_min, n_have_min;
    logic [IDX_W-1:0]   r_key, n_key;
    logic [IDX_W-1:0]   r_min, n_min;
    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_element, n_element;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic               r_last, n_last;

    logic               w_re;
    logic               w_we;
    logic               w_scan_done;
    logic               w_cand;
    logic               w_start_ins;
    logic [IDX_W-1:0]   w_rdata;
    t_cmp_res           w_cmp;

    function automatic logic [OCC_W-1:0] f_occ(input logic [CW-1:0] c);
        logic [CW+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, c};
        return wide[OCC_W-1:0];
    endfunction

    dss_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    dss_cmp u_cmp (
        .i_data (w_rdata),
        .i_key  (r_key),
        .i_min  (r_min),
        .o_res  (w_cmp)
    );

    assign w_re        = (r_state != S_IDLE) && (r_addr < r_count);
    assign w_scan_done = (r_addr == r_count) && !r_pend;
    assign w_we        = (r_state == S_INS) && w_scan_done && !r_found
                         && (r_count != CW'(CAPACITY));
    // candidate for the next sorted element: above the last one sent, below best so far
    assign w_cand      = (!r_have_thr || w_cmp.gt_key) && (!r_have_min || w_cmp.lt_min);
    assign w_start_ins = start && !busy && (t_op'(i_operation) == OP_INSERT);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_emit_cnt = r_emit_cnt;
        n_pend     = 1'b0;
        n_found    = r_found;
        n_have_thr = r_have_thr;
        n_have_min = r_have_min;
        n_key      = r_key;
        n_min      = r_min;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_element  = r_element;
        n_occ      = r_occ;
        n_last     = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_addr = '0;
                    if (t_op'(i_operation) == OP_INSERT) begin
                        n_key   = i_index_value;
                        n_found = 1'b0;
                        n_state = S_INS;
                    end else if (r_count == '0) begin
                        n_strobe  = 1'b1;
                        n_status  = ST_EMPTY;
                        n_element = '0;
                        n_occ     = '0;
                        n_last    = 1'b1;
                    end else begin
                        n_have_thr = 1'b0;
                        n_have_min = 1'b0;
                        n_emit_cnt = '0;
                        n_state    = S_RD;
                    end
                end
            end
            S_INS: begin
                n_pend = w_re;
                n_addr = r_addr + CW'(w_re);
                if (r_pend && w_cmp.eq) begin
                    n_found = 1'b1;
                end
                if (w_scan_done) begin
                    n_strobe  = 1'b1;
                    n_element = r_key;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                    priority if (r_found) begin
                        n_status = ST_PRESENT;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_ADDED;
                        n_count  = r_count + CW'(1);
                    end
                    n_occ = f_occ(n_count);
                end
            end
            S_RD: begin
                n_pend = w_re;
                n_addr = r_addr + CW'(w_re);
                if (r_pend && w_cand) begin
                    n_min      = w_rdata;
                    n_have_min = 1'b1;
                end
                if (w_scan_done) begin
                    n_strobe   = 1'b1;
                    n_status   = ST_ELEMENT;
                    n_element  = r_min;
                    n_occ      = f_occ(r_count);
                    n_last     = (r_emit_cnt + CW'(1) == r_count);
                    n_emit_cnt = r_emit_cnt + CW'(1);
                    n_key      = r_min;
                    n_have_thr = 1'b1;
                    n_have_min = 1'b0;
                    n_addr     = '0;
                    n_pend     = 1'b0;
                    if (r_emit_cnt + CW'(1) == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_addr     <= '0;
            r_emit_cnt <= '0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_have_thr <= 1'b0;
            r_have_min <= 1'b0;
            r_strobe   <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_addr     <= n_addr;
            r_emit_cnt <= n_emit_cnt;
            r_pend     <= n_pend;
            r_found    <= n_found;
            r_have_thr <= n_have_thr;
            r_have_min <= n_have_min;
            r_strobe   <= n_strobe;
            r_last     <= n_last;
        end
        r_key     <= n_key;
        r_min     <= n_min;
        r_status  <= n_status;
        r_element <= n_element;
        r_occ     <= n_occ;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_element   = r_element;
    assign o_occupancy = r_occ;
    assign o_last      = r_last;

    `DSS_ASSERT_IMPL(a_count_max, 1'b1, r_count <= CW'(CAPACITY), "set count above capacity")
    `DSS_ASSERT_IMPL(a_write_room, w_we, r_count < CW'(CAPACITY), "store write with no room")
    `DSS_ASSERT_NEXT(a_insert_busy, w_start_ins, busy, "insert did not start scan")
    `DSS_ASSERT_IMPL(a_last_idle, o_strobe && o_last, !busy, "final result while still busy")
    `DSS_ASSERT_IMPL(a_mid_busy, o_strobe && !o_last, busy, "non-final result while idle")

endmodule

@@ tb/tb_dedup_set_sorted_readout.sv @@
// Self-checking testbench for dedup_set_sorted_readout: directed table, then random phases.
// Depends on dss_pkg and the block's RTL; predicts results with its own set model, or takes them from the table.
`timescale 1ns / 1ps

module tb_dedup_set_sorted_readout
    import dss_pkg::*;
;

    localparam int CAPACITY       = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 64;
    localparam int DRAIN_CYCLES   = 80;
    localparam int ITEMS_PER_PASS = 55;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] element;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } set_result_t;

    typedef struct {
        t_op              op;
        logic [IDX_W-1:0] idx;
        int               rep;
        logic [IDX_W-1:0] stride;
        bit               typed;
        set_result_t      want;
    } dir_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_operation = 1'b0;
    logic [IDX_W-1:0] i_index_value = '0;
    logic             o_strobe;
    logic [ST_W-1:0]  o_status;
    logic [IDX_W-1:0] o_element;
    logic [OCC_W-1:0] o_occupancy;
    logic             o_last;

    // own copy of the set
    logic [IDX_W-1:0] model_entries [CAPACITY];
    int               model_count = 0;

    set_result_t expected_results [$];
    dir_row_t    directed_rows [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;

    dedup_set_sorted_readout #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_index_value(i_index_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_element    (o_element),
        .o_occupancy  (o_occupancy),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40) begin
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Applies one transaction to the set and queues the results it causes.
    function automatic void predict_set_op(t_op op, logic [IDX_W-1:0] idx);
        int               i;
        int               j;
        bit               found;
        logic [IDX_W-1:0] v;
        set_result_t      r;
        found = 1'b0;
        if (op == OP_INSERT) begin
            for (i = 0; i < model_count; i++) begin
                if (model_entries[i] == idx) found = 1'b1;
            end
            if (found) begin
                r.status = ST_PRESENT;
            end else if (model_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                model_entries[model_count] = idx;
                model_count++;
                r.status = ST_ADDED;
            end
            r.element   = idx;
            r.occupancy = OCC_W'(model_count);
            r.last      = 1'b1;
            expected_results.push_back(r);
        end else if (model_count == 0) begin
            r.status    = ST_EMPTY;
            r.element   = '0;
            r.occupancy = '0;
            r.last      = 1'b1;
            expected_results.push_back(r);
        end else begin
            // model copy is left sorted; later inserts append behind
            for (i = 1; i < model_count; i++) begin
                v = model_entries[i];
                j = i;
                while (j > 0 && model_entries[j-1] > v) begin
                    model_entries[j] = model_entries[j-1];
                    j--;
                end
                model_entries[j] = v;
            end
            for (i = 0; i < model_count; i++) begin
                r.status    = ST_ELEMENT;
                r.element   = model_entries[i];
                r.occupancy = OCC_W'(model_count);
                r.last      = (i == model_count - 1);
                expected_results.push_back(r);
            end
        end
    endfunction

    function automatic void add_row(t_op op, logic [IDX_W-1:0] idx, bit typed, t_status st,
                                    logic [IDX_W-1:0] elem, int occ, int rep,
                                    logic [IDX_W-1:0] stride);
        dir_row_t row;
        row.op             = op;
        row.idx            = idx;
        row.rep            = rep;
        row.stride         = stride;
        row.typed          = typed;
        row.want.status    = st;
        row.want.element   = elem;
        row.want.occupancy = OCC_W'(occ);
        row.want.last      = 1'b1;
        directed_rows.push_back(row);
    endfunction

    // Offers one transaction after an optional idle gap and waits until the block is no longer busy.
    task automatic issue_cmd(t_op op, logic [IDX_W-1:0] idx, int gap, bit typed,
                             set_result_t want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_index_value <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_set_op(op, idx);
        if (typed) expected_results[expected_results.size()-1] = want;
    endtask

    function automatic int idle_gap(int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(0, 99) < pct) g++;
        return g;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int               sel;
        logic [IDX_W-1:0] v;
        sel = $urandom_range(0, 99);
        v   = IDX_W'($urandom());
        if (sel < 45 && model_count > 0) begin
            v = model_entries[$urandom_range(0, model_count - 1)];
        end else if (sel < 52) begin
            v = IDX_W'(1) << $urandom_range(0, IDX_W - 1);
        end else if (sel < 58) begin
            v = ~(IDX_W'(1) << $urandom_range(0, IDX_W - 1));
        end else if (sel < 62) begin
            v = ($urandom_range(0, 1) == 0) ? '0 : '1;
        end
        return v;
    endfunction

    // checker and watchdog
    always @(posedge i_clk) begin
        set_result_t want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {29'd0, o_status}, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", {29'd0, o_status}, {29'd0, want.status});
                if (o_element !== want.element)
                    report_mismatch("element", {1'b0, o_element}, {1'b0, want.element});
                if (o_occupancy !== want.occupancy)
                    report_mismatch("occupancy", {26'd0, o_occupancy}, {26'd0, want.occupancy});
                if (o_last !== want.last)
                    report_mismatch("last", {31'd0, o_last}, {31'd0, want.last});
            end
        end
        if ((start && !busy) || o_strobe) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL dedup_set_sorted_readout");
            $finish;
        end
    end

    initial begin
        int          r;
        int          k;
        int          pass;
        int          pct;
        int          gap;
        t_op         op;
        dir_row_t    row;
        set_result_t none;
        int          idle_pct [3];

        idle_pct = '{0, 86, 28};
        none = '{ST_ADDED, '0, '0, 1'b0};

        add_row(OP_READOUT, 31'h0000_0000, 1, ST_EMPTY, 31'h0, 0, 1, '0);
        add_row(OP_READOUT, 31'h7FFF_FFFF, 1, ST_EMPTY, 31'h0, 0, 1, '0);
        add_row(OP_INSERT, 31'h7FFF_FFFF, 1, ST_ADDED, 31'h7FFF_FFFF, 1, 1, '0);
        add_row(OP_INSERT, 31'h0000_0000, 1, ST_ADDED, 31'h0000_0000, 2, 1, '0);
        add_row(OP_INSERT, 31'h7FFF_FFFF, 1, ST_PRESENT, 31'h7FFF_FFFF, 2, 1, '0);
        add_row(OP_INSERT, 31'h0000_0000, 1, ST_PRESENT, 31'h0000_0000, 2, 1, '0);
        add_row(OP_INSERT, 31'h4000_0000, 1, ST_ADDED, 31'h4000_0000, 3, 1, '0);
        add_row(OP_INSERT, 31'h0000_0001, 1, ST_ADDED, 31'h0000_0001, 4, 1, '0);
        add_row(OP_INSERT, 31'h3FFF_FFFF, 1, ST_ADDED, 31'h3FFF_FFFF, 5, 1, '0);
        add_row(OP_READOUT, 31'h2AAA_AAAA, 0, ST_ELEMENT, 31'h0, 0, 1, '0);
        // appended behind the model's now sorted entries
        add_row(OP_INSERT, 31'h2AAA_AAAA, 1, ST_ADDED, 31'h2AAA_AAAA, 6, 1, '0);
        add_row(OP_INSERT, 31'h5555_5555, 1, ST_ADDED, 31'h5555_5555, 7, 1, '0);
        add_row(OP_INSERT, 31'h4000_0000, 1, ST_PRESENT, 31'h4000_0000, 7, 1, '0);
        add_row(OP_READOUT, 31'h0000_0000, 0, ST_ELEMENT, 31'h0, 0, 1, '0);
        // fill the store to capacity
        add_row(OP_INSERT, 31'h0765_4321, 0, ST_ADDED, 31'h0, 0, CAPACITY - 7, 31'h0123_4567);
        add_row(OP_INSERT, 31'h1234_5678, 1, ST_FULL, 31'h1234_5678, 32, 1, '0);
        add_row(OP_INSERT, 31'h0000_0000, 1, ST_PRESENT, 31'h0000_0000, 32, 1, '0);
        add_row(OP_INSERT, 31'h7FFF_FFFF, 1, ST_PRESENT, 31'h7FFF_FFFF, 32, 1, '0);
        add_row(OP_READOUT, 31'h0000_0000, 0, ST_ELEMENT, 31'h0, 0, 1, '0);
        add_row(OP_INSERT, 31'h7FFF_FFFE, 1, ST_FULL, 31'h7FFF_FFFE, 32, 1, '0);
        add_row(OP_READOUT, 31'h5555_5555, 0, ST_ELEMENT, 31'h0, 0, 1, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            for (k = 0; k < row.rep; k++) begin
                issue_cmd(row.op, row.idx + IDX_W'(k) * row.stride, 0, row.typed, row.want);
            end
        end

        for (pass = 0; pass < 3; pass++) begin
            pct = idle_pct[pass];
            for (k = 0; k < ITEMS_PER_PASS; k++) begin
                r   = $urandom_range(0, 99);
                op  = (r < 18) ? OP_READOUT : OP_INSERT;
                gap = idle_gap(pct);
                issue_cmd(op, pick_index(), gap, 1'b0, none);
            end
        end
        start <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS dedup_set_sorted_readout");
        end else begin
            $display("FAIL dedup_set_sorted_readout");
        end
        $finish;
    end

endmodule
